[design/irc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the interrupt routing controller.
// No dependencies; every other design and test file but irc_checker imports this package.
package irc_pkg;

	localparam int NUM_IRQS      = 64;
	localparam int BASE_ADDRESS  = 57344;
	localparam int ENTRIES_START = 16;
	localparam int ENTRY_BYTES   = 4;
	localparam int IMAGE_BYTES   = ENTRIES_START + ENTRY_BYTES * NUM_IRQS;
	localparam int OFF_W         = $clog2(IMAGE_BYTES);
	localparam int MAX_ACCESS    = 4;
	localparam int IPI_CPU_OFF   = 4;

	// Bus command codes.
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_IRQ   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Decoded request handed from the decoder to the sequencer.
	typedef struct packed {
		op_t              kind;
		logic             go;
		logic [OFF_W-1:0] offset;
		logic [2:0]       count;
	} req_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_WRITE = 5'b00100,
		ST_READ  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

[design/interrupt_routing_controller_core.sv]
`timescale 1ns / 1ps
// Top level of the interrupt routing controller: byte-serial sequencer and register image.
// Depends on irc_pkg and irc_decode.
//
// Usage. Requests arrive on the s_ channel (command, address, access_size,
// write_data, irq_line); one response per request leaves on the m_ channel
// (ok, read_data, raise, raise_cpu, raise_vector). A request is taken when
// s_tvalid and s_tready are both high, a response when m_tvalid and m_tready are.
// The 272-byte register image sits in a byte-wide memory with one write port
// and one registered read port, so all data moves one byte per cycle.
// A read or an interrupt event passes through the byte read pass, then a state that
// forms the response, then the output register that presents it. A write of n bytes
// writes them one per cycle and then forms the response; when it starts at the control
// word with bit 0 set, the IPI target and vector are then fetched by a read pass. A
// rejected request goes straight to forming its response. One request is handled at
// a time: a new one is taken only once the previous one has left the sequencer for
// the output register.
// Reset: after arst_n rises the image is cleared one byte per cycle, with s_tready low.
// When the receiver stalls, the finished response waits in the output register; a new
// request is still taken, and its response waits until the previous one has been taken.
module interrupt_routing_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] command, [17:2] address, [20:18] access_size, [52:21] write_data,
	// [60:53] irq_line, [63:61] zero
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] ok, [32:1] read_data, [33] raise, [49:34] raise_cpu,
	// [65:50] raise_vector, [71:66] zero
	output logic [71:0] m_tdata
);
	import irc_pkg::*;

	state_t           state_q;
	logic [OFF_W-1:0] cnt_q;
	op_t              kind_q;
	logic             go_q;
	logic             ipi_q;
	logic [OFF_W-1:0] off_q;
	logic [2:0]       size_q;
	logic [31:0]      wdata_q;
	logic [31:0]      shift_q;
	logic             take_q;
	logic             out_valid_q;
	logic [71:0]      out_data_q;

	logic [7:0]       image_q [IMAGE_BYTES];
	logic [7:0]       rd_q;

	req_t             req;
	logic             accept;
	logic             out_free;
	logic             wr_en;
	logic [OFF_W-1:0] wr_addr;
	logic [7:0]       wr_byte;
	logic             rd_en;
	logic [OFF_W-1:0] rd_addr;
	logic [7:0]       in_byte;
	logic             resp_ok;
	logic             resp_raise;
	logic [31:0]      resp_rdata;
	logic [15:0]      resp_cpu;
	logic [15:0]      resp_vec;

	irc_decode u_decode (
		.command     (s_tdata[1:0]),
		.address     (s_tdata[17:2]),
		.access_size (s_tdata[20:18]),
		.irq_line    (s_tdata[60:53]),
		.req         (req)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The write port serves the clearing pass and byte writes.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_byte = 8'd0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == ST_WRITE) begin
			wr_en   = 1'b1;
			wr_addr = off_q + OFF_W'(cnt_q[2:0]);
			wr_byte = wdata_q[7:0];
		end
	end

	// The read pass always covers all four byte positions so short reads end up right-aligned.
	assign rd_en   = (state_q == ST_READ) && ({{(OFF_W-3){1'b0}}, size_q} > cnt_q);
	assign rd_addr = off_q + OFF_W'(cnt_q[2:0]);
	assign in_byte = take_q ? rd_q : 8'd0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			image_q[wr_addr] <= wr_byte;
		end
		if (rd_en) begin
			rd_q <= image_q[rd_addr];
		end
	end

	// Response fields; an interrupt entry is gathered as vector, CPU, flags low, flags high.
	always_comb begin
		resp_ok    = 1'b0;
		resp_raise = 1'b0;
		resp_rdata = 32'd0;
		resp_cpu   = 16'd0;
		resp_vec   = 16'd0;
		unique case (kind_q)
			OP_READ: begin
				resp_ok    = go_q;
				resp_rdata = go_q ? shift_q : 32'd0;
			end
			OP_WRITE: begin
				resp_ok    = go_q;
				resp_raise = go_q && ipi_q;
				if (go_q && ipi_q) begin
					resp_cpu = shift_q[15:0];
					resp_vec = shift_q[31:16];
				end
			end
			OP_IRQ: begin
				resp_ok    = go_q && shift_q[16];
				resp_raise = go_q && shift_q[16];
				if (go_q && shift_q[16]) begin
					resp_cpu = {8'd0, shift_q[15:8]};
					resp_vec = {8'd0, shift_q[7:0]};
				end
			end
			default: begin
				resp_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			take_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A finished response is loaded whenever the output register is free.
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == OFF_W'(IMAGE_BYTES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					cnt_q  <= '0;
					take_q <= 1'b0;
					if (accept) begin
						if (!req.go) begin
							state_q <= ST_DONE;
						end else if (req.kind == OP_WRITE) begin
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_WRITE: begin
					if (cnt_q[2:0] == size_q - 3'd1) begin
						cnt_q   <= '0;
						state_q <= ipi_q ? ST_READ : ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_READ: begin
					take_q <= rd_en;
					if (cnt_q == OFF_W'(MAX_ACCESS)) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.kind;
			go_q    <= req.go;
			off_q   <= req.offset;
			size_q  <= req.count;
			wdata_q <= s_tdata[52:21];
			// Only a write starting at the control word can send an IPI; the
			// control byte after the write is the first written byte.
			ipi_q   <= (req.offset == '0) && s_tdata[21];
		end
		if (state_q == ST_WRITE) begin
			wdata_q <= {8'd0, wdata_q[31:8]};
			if (cnt_q[2:0] == size_q - 3'd1) begin
				off_q  <= OFF_W'(IPI_CPU_OFF);
				size_q <= 3'(MAX_ACCESS);
			end
		end
		if ((state_q == ST_READ) && (cnt_q != '0)) begin
			shift_q <= {in_byte, shift_q[31:8]};
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_data_q <= {6'd0, resp_vec, resp_cpu, resp_raise, resp_rdata, resp_ok};
		end
	end

endmodule

[design/irc_decode.sv]
`timescale 1ns / 1ps
// Request decoder: range and size checks, image offset of an access or IRQ entry.
// Depends on irc_pkg.
module irc_decode (
	input  logic [1:0]    command,
	input  logic [15:0]   address,
	input  logic [2:0]    access_size,
	input  logic [7:0]    irq_line,
	output irc_pkg::req_t req
);
	import irc_pkg::*;

	logic [16:0]      off_full;
	logic [16:0]      span;
	logic             size_ok;
	logic             addr_ok;
	logic             fits;
	logic             irq_ok;
	logic [OFF_W-1:0] entry_off;

	always_comb begin
		off_full  = {1'b0, address} - 17'(BASE_ADDRESS);
		span      = off_full + 17'(access_size);
		size_ok   = (access_size != 3'd0) && (access_size <= 3'(MAX_ACCESS));
		addr_ok   = address >= 16'(BASE_ADDRESS);
		fits      = span <= 17'(IMAGE_BYTES);
		irq_ok    = {1'b0, irq_line} < 9'(NUM_IRQS);
		entry_off = OFF_W'(ENTRIES_START) + OFF_W'({irq_line, 2'b00});
		req.kind   = op_t'(command);
		req.go     = 1'b0;
		req.offset = off_full[OFF_W-1:0];
		req.count  = access_size;
		unique case (op_t'(command))
			OP_READ, OP_WRITE: begin
				req.go = size_ok && addr_ok && fits;
			end
			OP_IRQ: begin
				req.go     = irq_ok;
				req.offset = entry_off;
				req.count  = 3'(ENTRY_BYTES);
			end
			default: begin
				req.go = 1'b0;
			end
		endcase
	end

endmodule

[design/irc_checker.sv]
`timescale 1ns / 1ps
// Port-level checker of the interrupt routing controller, bound to the top level.
// Depends on interrupt_routing_controller_core's port list only.
module irc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// A stalled response holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled response changed");

	// The block works on one request at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// Without a raise, target CPU and vector are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[33] |-> m_tdata[65:34] == 32'd0)
		else $error("raise fields set without raise");

	// Read data shows only on an accepted request that raises nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[32:1] != 32'd0) |-> m_tdata[0] && !m_tdata[33])
		else $error("read data on a failed or raising response");

	// A raise always comes with ok.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> m_tdata[0])
		else $error("raise without ok");

endmodule

bind interrupt_routing_controller_core irc_checker u_irc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[verif/irc_response_checker.sv]
`timescale 1ns / 1ps
// Response checker for the interrupt routing controller. It keeps its own copy of the
// register image, predicts one response per accepted request and compares it with the output.
// Depends on irc_pkg only.
module irc_response_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	output int          fail_count,
	output int          pending
);
	import irc_pkg::*;

	localparam int IPI_VEC_OFF = 6;
	localparam int ENTRY_CPU   = 1;
	localparam int ENTRY_FLAGS = 2;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic        ok;
		logic [31:0] read_data;
		logic        raise;
		logic [15:0] raise_cpu;
		logic [15:0] raise_vector;
	} irc_response_t;

	logic [7:0]    image_copy [IMAGE_BYTES];
	irc_response_t awaited [$];
	int            mismatches;

	// True when the whole access lies inside the image; offset is the image byte it starts at.
	function automatic bit access_in_image(input logic [15:0] address, input logic [2:0] size,
			output int offset);
		offset = int'(address) - BASE_ADDRESS;
		return (int'(size) >= 1) && (int'(size) <= MAX_ACCESS) && (offset >= 0)
			&& (offset + int'(size) <= IMAGE_BYTES);
	endfunction

	// Applies one request to the image copy and returns the response it must produce.
	function automatic irc_response_t route_request(input logic [63:0] word);
		op_t           command;
		logic [15:0]   address;
		logic [2:0]    size;
		logic [31:0]   wdata;
		logic [7:0]    irq;
		int            offset;
		int            entry;
		irc_response_t rsp;
		command = op_t'(word[1:0]);
		address = word[17:2];
		size    = word[20:18];
		wdata   = word[52:21];
		irq     = word[60:53];
		rsp     = '0;
		case (command)
			OP_READ: begin
				if (access_in_image(address, size, offset)) begin
					for (int i = 0; i < int'(size); i++)
						rsp.read_data[8*i +: 8] = image_copy[offset + i];
					rsp.ok = 1'b1;
				end
			end
			OP_WRITE: begin
				if (access_in_image(address, size, offset)) begin
					for (int i = 0; i < int'(size); i++)
						image_copy[offset + i] = wdata[8*i +: 8];
					rsp.ok = 1'b1;
					// Only a write that starts on the control word can send the IPI.
					if (offset == 0 && image_copy[0][0]) begin
						rsp.raise        = 1'b1;
						rsp.raise_cpu    = {image_copy[IPI_CPU_OFF + 1], image_copy[IPI_CPU_OFF]};
						rsp.raise_vector = {image_copy[IPI_VEC_OFF + 1], image_copy[IPI_VEC_OFF]};
					end
				end
			end
			OP_IRQ: begin
				if (int'(irq) < NUM_IRQS) begin
					entry = ENTRIES_START + ENTRY_BYTES * int'(irq);
					if (image_copy[entry + ENTRY_FLAGS][0]) begin
						rsp.ok           = 1'b1;
						rsp.raise        = 1'b1;
						rsp.raise_vector = {8'h00, image_copy[entry]};
						rsp.raise_cpu    = {8'h00, image_copy[entry + ENTRY_CPU]};
					end
				end
			end
			default: begin
			end
		endcase
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		irc_response_t seen;
		irc_response_t want;
		if (!arst_n) begin
			for (int i = 0; i < IMAGE_BYTES; i++)
				image_copy[i] = 8'h00;
			awaited.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.ok           = m_tdata[0];
				seen.read_data    = m_tdata[32:1];
				seen.raise        = m_tdata[33];
				seen.raise_cpu    = m_tdata[49:34];
				seen.raise_vector = m_tdata[65:50];
				if (awaited.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: response with no request outstanding: ok=%0d rdata=%08h",
							$realtime, seen.ok, seen.read_data);
					mismatches++;
				end else begin
					want = awaited.pop_front();
					if (seen != want) begin
						if (mismatches < REPORT_MAX) begin
							$display("%0t: expected ok=%0d rdata=%08h raise=%0d cpu=%04h vec=%04h",
								$realtime, want.ok, want.read_data, want.raise,
								want.raise_cpu, want.raise_vector);
							$display("%0t: got      ok=%0d rdata=%08h raise=%0d cpu=%04h vec=%04h",
								$realtime, seen.ok, seen.read_data, seen.raise,
								seen.raise_cpu, seen.raise_vector);
						end
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				awaited.push_back(route_request(s_tdata));
			fail_count <= mismatches;
			pending    <= awaited.size();
		end
	end

endmodule

[verif/tb_interrupt_routing_controller_core.sv]
`timescale 1ns / 1ps
// Testbench top of the interrupt routing controller: clock, reset, request and response
// traffic, random idling, verdict. Depends on irc_pkg, the core, irc_response_checker.
module tb_interrupt_routing_controller_core;
	import irc_pkg::*;

	localparam int          RANDOM_ITEMS  = 1330;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          DRAIN_CYCLES  = 30;
	localparam logic [15:0] IMG_BASE      = 16'(BASE_ADDRESS);
	localparam logic [15:0] IMG_END       = 16'(BASE_ADDRESS + IMAGE_BYTES);

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	int          fail_count;
	int          pending;
	bit          tx_steady = 1'b0;

	always #2 clk = ~clk;

	interrupt_routing_controller_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	irc_response_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Idle cycles before the next request or response; none during a steady stretch.
	function automatic int draw_pause(input bit steady);
		if (steady || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// Packs the request fields into the s_tdata layout, command in the lowest bits.
	function automatic logic [63:0] pack_request(input op_t cmd, input logic [15:0] addr,
			input logic [2:0] size, input logic [31:0] data, input logic [7:0] irq);
		return {3'b000, irq, data, size, addr, cmd};
	endfunction

	// Mostly inside the image, sometimes straddling either end, now and then anywhere.
	function automatic logic [15:0] pick_address();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return 16'(BASE_ADDRESS + $urandom_range(0, IMAGE_BYTES - 1));
		if (r == 8)
			return ($urandom_range(0, 1) ? IMG_BASE - 16'd4 : IMG_END - 16'd4)
				+ 16'($urandom_range(0, 7));
		return 16'($urandom);
	endfunction

	function automatic logic [2:0] pick_size();
		if ($urandom_range(0, 9) != 0)
			return 3'($urandom_range(1, 4));
		return 3'($urandom_range(0, 7));
	endfunction

	// Random request: mostly well-formed reads, writes and line events, with a share of
	// entry programming so that events get delivered, IPI sends, and some pure noise.
	function automatic logic [63:0] random_request();
		int          pick;
		logic [15:0] addr;
		logic [2:0]  size;
		logic [31:0] data;
		logic [7:0]  irq;
		pick = $urandom_range(0, 99);
		addr = pick_address();
		size = pick_size();
		data = $urandom;
		irq  = 8'($urandom_range(0, NUM_IRQS - 1));
		if (pick < 28)
			return pack_request(OP_READ, addr, size, data, irq);
		if (pick < 40) begin
			// Program a whole entry, usually with the enable bit set.
			data[16] = ($urandom_range(0, 3) != 0);
			addr = 16'(BASE_ADDRESS + ENTRIES_START + ENTRY_BYTES * $urandom_range(0, NUM_IRQS - 1));
			return pack_request(OP_WRITE, addr, 3'd4, data, irq);
		end
		if (pick < 48) begin
			// Control, IPI target and vector words; at least half of these start on control.
			addr = $urandom_range(0, 1) ? IMG_BASE : IMG_BASE + 16'($urandom_range(0, 7));
			return pack_request(OP_WRITE, addr, size, data, irq);
		end
		if (pick < 58)
			return pack_request(OP_WRITE, addr, size, data, irq);
		if (pick < 88) begin
			if ($urandom_range(0, 7) == 0)
				irq = 8'($urandom);
			return pack_request(OP_IRQ, addr, size, data, irq);
		end
		return pack_request(op_t'($urandom_range(0, 3)), 16'($urandom), 3'($urandom_range(0, 7)),
			$urandom, 8'($urandom));
	endfunction

	// Offers one request and returns at the edge where it is accepted. The valid stays
	// high across back-to-back requests and drops here only when a pause is drawn.
	task automatic offer_request(input logic [63:0] word);
		int gap;
		gap = draw_pause(tx_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	// Waits until every issued request has been answered.
	task automatic wait_all_answered();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Response side. Besides the random stalls it holds off twice for a long stretch so
	// that the output register and the request in flight fill up and s_tready drops.
	initial begin : response_sink
		int taken;
		int stall;
		bit steady;
		taken  = 0;
		steady = 1'b0;
		forever begin
			if (taken == 300 || taken == 1000) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = draw_pause(steady);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
			if (taken % 97 == 0)
				steady = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin : run_limit
		#2_000_000;
		$display("tb_interrupt_routing_controller_core: FAIL");
		$finish;
	end

	initial begin : request_source
		logic [63:0] directed [$];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Range and size edges on an image that is still all zero.
		directed.push_back(pack_request(OP_READ, IMG_BASE, 3'd4, 32'h0, 8'h0));
		directed.push_back(pack_request(OP_READ, IMG_BASE, 3'd0, 32'h0, 8'h0));
		directed.push_back(pack_request(OP_READ, IMG_BASE, 3'd7, 32'h0, 8'h0));
		directed.push_back(pack_request(OP_WRITE, IMG_BASE + 16'd8, 3'd5, 32'hFFFF_FFFF, 8'h0));
		directed.push_back(pack_request(OP_WRITE, IMG_BASE + 16'd8, 3'd6, 32'hFFFF_FFFF, 8'h0));
		directed.push_back(pack_request(OP_READ, IMG_BASE - 16'd1, 3'd1, 32'h0, 8'h0));
		directed.push_back(pack_request(OP_WRITE, IMG_BASE - 16'd1, 3'd4, 32'hFFFF_FFFF, 8'h0));
		directed.push_back(pack_request(OP_READ, IMG_END - 16'd1, 3'd1, 32'h0, 8'h0));
		directed.push_back(pack_request(OP_READ, IMG_END - 16'd3, 3'd4, 32'h0, 8'h0));
		directed.push_back(pack_request(OP_READ, 16'hFFFF, 3'd4, 32'h0, 8'hFF));
		directed.push_back(pack_request(OP_READ, 16'h0000, 3'd1, 32'h0, 8'h0));
		// IPI target and vector, then sends: bit 0 set, bit 0 clear, a write that does
		// not start on the control word, and bit 0 set again.
		directed.push_back(pack_request(OP_WRITE, IMG_BASE + 16'd4, 3'd4, 32'h1234_ABCD, 8'h0));
		directed.push_back(pack_request(OP_WRITE, IMG_BASE, 3'd1, 32'h0000_0001, 8'h0));
		directed.push_back(pack_request(OP_WRITE, IMG_BASE, 3'd4, 32'hFFFF_FFFE, 8'h0));
		directed.push_back(pack_request(OP_WRITE, IMG_BASE + 16'd1, 3'd1, 32'h0000_00FF, 8'h0));
		directed.push_back(pack_request(OP_WRITE, IMG_BASE, 3'd4, 32'hFFFF_FFFF, 8'h0));
		// Last entry enabled, events on it and disabled line 1; first entry all ones, events on it and bad lines.
		directed.push_back(pack_request(OP_WRITE, IMG_END - 16'd4, 3'd4, 32'h0001_5A7E, 8'h0));
		directed.push_back(pack_request(OP_IRQ, 16'h0, 3'd0, 32'h0, 8'd63));
		directed.push_back(pack_request(OP_IRQ, 16'h0, 3'd0, 32'h0, 8'd1));
		directed.push_back(pack_request(OP_WRITE, IMG_BASE + 16'd16, 3'd4, 32'hFFFF_FFFF, 8'h0));
		directed.push_back(pack_request(OP_IRQ, 16'h0, 3'd0, 32'h0, 8'd0));
		directed.push_back(pack_request(OP_IRQ, 16'h0, 3'd0, 32'h0, 8'd64));
		directed.push_back(pack_request(OP_IRQ, 16'h0, 3'd0, 32'h0, 8'd255));
		directed.push_back(pack_request(OP_NONE, IMG_BASE, 3'd4, 32'hFFFF_FFFF, 8'd0));
		directed.push_back(pack_request(OP_READ, IMG_END - 16'd4, 3'd4, 32'h0, 8'h0));
		directed.push_back(pack_request(OP_READ, IMG_BASE + 16'd6, 3'd2, 32'h0, 8'h0));
		foreach (directed[i])
			offer_request(directed[i]);
		wait_all_answered();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0)
				tx_steady = ($urandom_range(0, 2) == 0);
			// Halfway through, the source goes quiet until the block has answered everything.
			if (n == RANDOM_ITEMS / 2)
				wait_all_answered();
			offer_request(random_request());
		end
		wait_all_answered();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("tb_interrupt_routing_controller_core: PASS");
		else
			$display("tb_interrupt_routing_controller_core: FAIL");
		$finish;
	end

endmodule

[filelist.f]
design/irc_pkg.sv
design/irc_decode.sv
design/interrupt_routing_controller_core.sv
design/irc_checker.sv
verif/irc_response_checker.sv
verif/tb_interrupt_routing_controller_core.sv
